FILE: rtl/satl_pkg.sv
// Shared constants, types and helpers for the set-associative tag lookup unit.
package satl_pkg;

  // Cache geometry
  localparam int WAYS         = 4;
  localparam int SET_COUNT    = 32;
  localparam int OFFSET_BITS  = 2;
  localparam int ADDRESS_BITS = 32;

  // Fixed field widths of the transaction payloads
  localparam int ADDR_W      = 32;
  localparam int SET_OUT_W   = 5;
  localparam int WAY_OUT_W   = 2;
  localparam int ETAG_OUT_W  = 25;
  localparam int CNT_W       = 32;
  localparam int TIME_CFG_W  = 8;

  // Derived geometry: index uses floor(log2(SET_COUNT)) bits
  localparam int IDX_BITS  = $clog2(SET_COUNT + 1) - 1;
  localparam int IDX_W     = (IDX_BITS > 0) ? IDX_BITS : 1;
  localparam int ROWS      = 1 << IDX_BITS;
  localparam int ADDR_USED = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
  localparam int TAG_RAW   = ADDR_USED - OFFSET_BITS - IDX_BITS;
  localparam int TAG_BITS  = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int PTR_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic [ADDR_W-1:0] ADDR_MASK =
    (ADDRESS_BITS >= ADDR_W) ? '1 : ((ADDR_W'(1) << ADDRESS_BITS) - ADDR_W'(1));
  localparam logic [ADDR_W-1:0] IDX_MASK = (ADDR_W'(1) << IDX_BITS) - ADDR_W'(1);

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_MODE     = 2'd0,
    REG_HIT_TIME = 2'd1,
    REG_MISS_PEN = 2'd2
  } satl_reg_t;

  localparam logic        MODE_RESET     = 1'b1;
  localparam logic [7:0]  HIT_TIME_RESET = 8'd1;
  localparam logic [7:0]  MISS_PEN_RESET = 8'd35;

  // One stored set: all ways plus both replacement pointers
  typedef struct packed {
    logic [WAYS-1:0]                valid;
    logic [WAYS-1:0][TAG_BITS-1:0]  tag;
    logic [PTR_BITS-1:0]            fifo_ptr;
    logic [PTR_BITS-1:0]            lastin_ptr;
  } satl_row_t;

  localparam int ROW_W = $bits(satl_row_t);

  localparam satl_row_t ROW_RESET = '{
    valid:      '0,
    tag:        '0,
    fifo_ptr:   '0,
    lastin_ptr: PTR_BITS'(WAYS - 1)
  };

  // Outcome of one set lookup
  typedef struct packed {
    logic                 hit;
    logic [PTR_BITS-1:0]  way;
    logic                 evicted;
    logic [TAG_BITS-1:0]  old_tag;
  } satl_lookup_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } satl_state_t;

  // Saturating 32-bit add of an 8-bit amount
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [TIME_CFG_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + (CNT_W+1)'(b);
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

endpackage

FILE: rtl/satl_if.sv
// Valid/ready channel interfaces for access requests and lookup results.
interface satl_req_if;
  logic                            valid;
  logic                            ready;
  logic [satl_pkg::ADDR_W-1:0]     address;
  logic                            is_write;

  modport source (output valid, output address, output is_write, input ready);
  modport sink   (input valid, input address, input is_write, output ready);
endinterface

interface satl_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              hit;
  logic [satl_pkg::SET_OUT_W-1:0]    set_index;
  logic [satl_pkg::WAY_OUT_W-1:0]    way;
  logic                              evicted;
  logic [satl_pkg::ETAG_OUT_W-1:0]   evicted_tag;
  logic [satl_pkg::CNT_W-1:0]        total_time;
  logic [satl_pkg::CNT_W-1:0]        read_hits;
  logic [satl_pkg::CNT_W-1:0]        read_misses;
  logic [satl_pkg::CNT_W-1:0]        write_hits;
  logic [satl_pkg::CNT_W-1:0]        write_misses;

  modport source (output valid, output hit, output set_index, output way, output evicted,
                  output evicted_tag, output total_time, output read_hits,
                  output read_misses, output write_hits, output write_misses,
                  input ready);
  modport sink   (input valid, input hit, input set_index, input way, input evicted,
                  input evicted_tag, input total_time, input read_hits,
                  input read_misses, input write_hits, input write_misses,
                  output ready);
endinterface

FILE: rtl/set_assoc_cache_tag_lookup_unit.sv
// Top level: set RAM, lookup sequencer, statistics counters and register port.
//
//   channel | dir | handshake       | payload
//   --------+-----+-----------------+-----------------------------------------------
//   req     | in  | valid/ready     | address, is_write
//   rsp     | out | valid/ready     | hit, set_index, way, evicted, evicted_tag,
//           |     |                 | total_time, read/write hit/miss counts
//   apb     | in  | psel/penable    | paddr, pwdata, pwrite -> prdata, pready
//
// The set is read from the set RAM on acceptance and written back on commit, when the
// result is registered; commit waits while an earlier result still waits on rsp.
// A new request is taken while a result still waits on rsp; the lookup then holds
// until the result register frees. Reset clears the per-set valid flags at once,
// so a set not yet written reads as empty and no clearing pass is needed.
module set_assoc_cache_tag_lookup_unit (
  input  logic                            clk,
  input  logic                            rst,
  satl_req_if.sink                        req,
  satl_rsp_if.source                      rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [satl_pkg::PADDR_W-1:0]    paddr,
  input  logic [satl_pkg::PDATA_W-1:0]    pwdata,
  output logic [satl_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);
  import satl_pkg::*;

  // Configuration registers
  logic                   replacement_mode;
  logic [TIME_CFG_W-1:0]  hit_time;
  logic [TIME_CFG_W-1:0]  miss_penalty;
  logic                   cfg_wr;
  satl_reg_t              cfg_sel;

  // Sequencer and captured request
  satl_state_t            state, state_next;
  logic                   accept;
  logic                   commit;
  logic [IDX_W-1:0]       set_q;
  logic [TAG_BITS-1:0]    tag_q;
  logic                   is_write_q;
  logic [ADDR_W-1:0]      addr_shift;
  logic [IDX_W-1:0]       req_set;
  logic [TAG_BITS-1:0]    req_tag;

  // Set storage
  logic [ROWS-1:0]        row_valid;
  logic [ROW_W-1:0]       ram_rd_data;
  satl_row_t              row_cur;
  satl_row_t              row_next;
  satl_lookup_t           res;

  // Statistics
  logic [CNT_W-1:0]       time_total;
  logic [CNT_W-1:0]       read_hit_count;
  logic [CNT_W-1:0]       read_miss_count;
  logic [CNT_W-1:0]       write_hit_count;
  logic [CNT_W-1:0]       write_miss_count;

  // Result register
  logic                   rsp_valid;
  logic                   rsp_hit;
  logic [SET_OUT_W-1:0]   rsp_set;
  logic [WAY_OUT_W-1:0]   rsp_way;
  logic                   rsp_evicted;
  logic [ETAG_OUT_W-1:0]  rsp_etag;
  logic [63:0]            etag_wide;

  // Register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = satl_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      replacement_mode <= MODE_RESET;
      hit_time         <= HIT_TIME_RESET;
      miss_penalty     <= MISS_PEN_RESET;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_MODE:     replacement_mode <= pwdata[0];
        REG_HIT_TIME: hit_time         <= pwdata[TIME_CFG_W-1:0];
        REG_MISS_PEN: miss_penalty     <= pwdata[TIME_CFG_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_MODE:     prdata = PDATA_W'(replacement_mode);
      REG_HIT_TIME: prdata = PDATA_W'(hit_time);
      REG_MISS_PEN: prdata = PDATA_W'(miss_penalty);
      default:      prdata = '0;
    endcase
  end

  // Address split
  assign addr_shift = (req.address & ADDR_MASK) >> OFFSET_BITS;
  assign req_set    = IDX_W'(addr_shift & IDX_MASK);
  assign req_tag    = TAG_BITS'(addr_shift >> IDX_BITS);

  // Sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = ST_LOOKUP;
      ST_LOOKUP: if (commit) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    req.ready = 1'b0;
    commit    = 1'b0;
    case (state)
      ST_IDLE:   req.ready = 1'b1;
      ST_LOOKUP: commit    = !rsp_valid || rsp.ready;
      default:   ;
    endcase
  end

  assign accept = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Captured request fields
  always_ff @(posedge clk) begin
    if (accept) begin
      set_q      <= req_set;
      tag_q      <= req_tag;
      is_write_q <= req.is_write;
    end
  end

  // Set RAM: read on acceptance, write back on commit
  satl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_set_ram (
    .clk     (clk),
    .wr_en   (commit),
    .wr_addr (set_q),
    .wr_data (row_next),
    .rd_en   (accept),
    .rd_addr (req_set),
    .rd_data (ram_rd_data)
  );

  // Sets never written read as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (commit) begin
      row_valid[set_q] <= 1'b1;
    end
  end

  assign row_cur = row_valid[set_q] ? satl_row_t'(ram_rd_data) : ROW_RESET;

  satl_way_sel u_way_sel (
    .row      (row_cur),
    .tag      (tag_q),
    .mode     (replacement_mode),
    .res      (res),
    .row_next (row_next)
  );

  // Statistics counters
  always_ff @(posedge clk) begin
    if (rst) begin
      time_total       <= '0;
      read_hit_count   <= '0;
      read_miss_count  <= '0;
      write_hit_count  <= '0;
      write_miss_count <= '0;
    end else if (commit) begin
      if (res.hit) begin
        time_total <= sat_add(time_total, hit_time);
        if (is_write_q) write_hit_count <= sat_add(write_hit_count, TIME_CFG_W'(1));
        else            read_hit_count  <= sat_add(read_hit_count, TIME_CFG_W'(1));
      end else begin
        time_total <= sat_add(time_total, miss_penalty);
        if (is_write_q) write_miss_count <= sat_add(write_miss_count, TIME_CFG_W'(1));
        else            read_miss_count  <= sat_add(read_miss_count, TIME_CFG_W'(1));
      end
    end
  end

  // Result register
  assign etag_wide = 64'(res.old_tag);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp_hit     <= res.hit;
      rsp_set     <= SET_OUT_W'(set_q);
      rsp_way     <= WAY_OUT_W'(res.way);
      rsp_evicted <= res.evicted;
      rsp_etag    <= etag_wide[ETAG_OUT_W-1:0];
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.hit          = rsp_hit;
  assign rsp.set_index    = rsp_set;
  assign rsp.way          = rsp_way;
  assign rsp.evicted      = rsp_evicted;
  assign rsp.evicted_tag  = rsp_etag;
  assign rsp.total_time   = time_total;
  assign rsp.read_hits    = read_hit_count;
  assign rsp.read_misses  = read_miss_count;
  assign rsp.write_hits   = write_hit_count;
  assign rsp.write_misses = write_miss_count;

endmodule

FILE: rtl/satl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module satl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/satl_way_sel.sv
// Tag compare, victim choice and updated set contents for one lookup.
module satl_way_sel (
  input  satl_pkg::satl_row_t                 row,
  input  logic [satl_pkg::TAG_BITS-1:0]       tag,
  input  logic                                mode,
  output satl_pkg::satl_lookup_t              res,
  output satl_pkg::satl_row_t                 row_next
);
  import satl_pkg::*;

  logic                 hit;
  logic [PTR_BITS-1:0]  hit_way;
  logic                 free;
  logic [PTR_BITS-1:0]  free_way;

  // Lowest valid matching way and lowest invalid way
  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    free     = 1'b0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row.valid[w] && (row.tag[w] == tag)) begin
        hit     = 1'b1;
        hit_way = PTR_BITS'(w);
      end
      if (!row.valid[w]) begin
        free     = 1'b1;
        free_way = PTR_BITS'(w);
      end
    end
  end

  // Choose the way to report and build the set to write back
  always_comb begin
    res      = '0;
    row_next = row;
    if (hit) begin
      res.hit = 1'b1;
      res.way = hit_way;
    end else if (free) begin
      res.way                 = free_way;
      row_next.valid[free_way] = 1'b1;
      row_next.tag[free_way]   = tag;
    end else begin
      res.evicted = 1'b1;
      if (mode == 1'b0) begin
        res.way = row.fifo_ptr;
        row_next.fifo_ptr = (row.fifo_ptr == PTR_BITS'(WAYS - 1)) ? '0
                                                                   : row.fifo_ptr + 1'b1;
      end else begin
        res.way = row.lastin_ptr;
        row_next.lastin_ptr = (row.lastin_ptr == '0) ? PTR_BITS'(WAYS - 1)
                                                     : row.lastin_ptr - 1'b1;
      end
      res.old_tag             = row.tag[res.way];
      row_next.tag[res.way]   = tag;
    end
  end

endmodule
